>>> hdl/varint_zigzag_codec_assert.svh
// Assertion macros for the varint codec. Each one checks a property on the
// rising edge of clock and is switched off while reset is high.
`ifndef VARINT_ZIGZAG_CODEC_ASSERT_SVH
`define VARINT_ZIGZAG_CODEC_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VZC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("varint codec assertion failed");

// Next-cycle implication.
`define VZC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("varint codec assertion failed");

`else

`define VZC_ASSERT_NOW(label, ante, cons)
`define VZC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/vzc_pkg.sv
`timescale 1ns / 1ps

package vzc_pkg;

   typedef logic op_type;
   typedef logic kind_type;
   typedef logic [3:0] count_type;
   typedef logic [6:0] group_type;

   localparam op_type OP_ENCODE = 1'b0;
   localparam op_type OP_DECODE = 1'b1;

   localparam kind_type KIND_BYTE  = 1'b0;
   localparam kind_type KIND_VALUE = 1'b1;

   // Bit 7 of a varint byte marks that another byte follows.
   localparam int CONT_POS = 7;
   localparam int GROUP_W  = 7;
   // At most ten groups cover a 64-bit value; the tenth holds only bit 63.
   localparam int MAX_GROUPS = 10;
   localparam count_type LAST_GROUP = 4'd9;

endpackage

>>> hdl/varint_zigzag_codec.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  operation, value, byte_in, is_wide, is_signed
// rsp_      out        rsp_valid / rsp_ready  kind, byte_out, value_out, last, overrun
//
// A decode item is accepted whenever the result register is free
// and no encode is in progress.
// An encode item of n bytes gives its first byte at acceptance,
// and the rest are shifted out of a 64-bit register seven bits per cycle unless stalled.
// The result register is the only stall point; rsp_ready low holds the encoder.
// Synchronous active-high reset clears the decoder accumulator and byte count.
`include "varint_zigzag_codec_assert.svh"

module varint_zigzag_codec (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vzc_pkg::op_type   req_operation,
   input  logic [63:0]       req_value,
   input  logic [7:0]        req_byte_in,
   input  logic              req_is_wide,
   input  logic              req_is_signed,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vzc_pkg::kind_type rsp_kind,
   output logic [7:0]        rsp_byte_out,
   output logic [63:0]       rsp_value_out,
   output logic              rsp_last,
   output logic              rsp_overrun
);
   import vzc_pkg::*;

   // Result register, shared by both directions.
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_overrun_ff, rsp_overrun_in;

   // Encoder shift register: holds the groups that are still to be sent.
   logic        enc_active_ff, enc_active_in;
   logic [63:0] enc_val_ff, enc_val_in;
   count_type   enc_cnt_ff, enc_cnt_in;

   // Decoder state.
   logic [63:0] acc_ff, acc_in;
   count_type   byte_cnt_ff, byte_cnt_in;

   logic        out_free;
   logic        req_fire;
   logic [63:0] enc_mapped;
   logic [63:0] acc_ins;
   logic [63:0] dec_masked;
   logic [63:0] dec_value;
   group_type   payload;
   logic        enc_more;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = out_free && !enc_active_ff;
   assign req_fire  = req_valid && req_ready;
   assign payload   = req_byte_in[GROUP_W-1:0];

   // Zigzag mapping and width selection for an encode item.
   always_comb begin
      if (req_is_wide) begin
         if (req_is_signed) begin
            enc_mapped = {req_value[62:0], 1'b0} ^ {64{req_value[63]}};
         end else begin
            enc_mapped = req_value;
         end
      end else begin
         if (req_is_signed) begin
            enc_mapped = {32'd0, {req_value[30:0], 1'b0} ^ {32{req_value[31]}}};
         end else begin
            enc_mapped = {32'd0, req_value[31:0]};
         end
      end
   end

   // Drop the incoming seven-bit group into its slot of the accumulator.
   // The tenth group lands on bit 63 alone; its upper bits fall off the word.
   always_comb begin
      acc_ins = acc_ff;
      for (int g = 0; g < MAX_GROUPS - 1; g++) begin
         if (byte_cnt_ff == count_type'(g)) begin
            acc_ins[g*GROUP_W +: GROUP_W] = acc_ff[g*GROUP_W +: GROUP_W] | payload;
         end
      end
      if (byte_cnt_ff == LAST_GROUP) begin
         acc_ins[63] = acc_ff[63] | payload[0];
      end
   end

   // Width truncation and zigzag unmapping of a finished varint.
   always_comb begin
      dec_masked = req_is_wide ? acc_ins : {32'd0, acc_ins[31:0]};
      if (!req_is_signed) begin
         dec_value = dec_masked;
      end else if (req_is_wide) begin
         dec_value = {1'b0, dec_masked[63:1]} ^ {64{dec_masked[0]}};
      end else begin
         dec_value = {{32{dec_masked[32] ^ dec_masked[0]}},
                      {1'b0, dec_masked[31:1]} ^ {32{dec_masked[0]}}};
      end
   end

   // More groups remain when the value left in the shift register is 0x80 or above.
   assign enc_more = (enc_val_ff[63:GROUP_W] != '0) && (enc_cnt_ff != LAST_GROUP);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_overrun_in = rsp_overrun_ff;
      enc_active_in  = enc_active_ff;
      enc_val_in     = enc_val_ff;
      enc_cnt_in     = enc_cnt_ff;
      acc_in         = acc_ff;
      byte_cnt_in    = byte_cnt_ff;

      if (enc_active_ff && out_free) begin
         // Send the next group from the shift register.
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = KIND_BYTE;
         rsp_byte_in    = {enc_more, enc_val_ff[GROUP_W-1:0]};
         rsp_value_in   = '0;
         rsp_last_in    = !enc_more;
         rsp_overrun_in = 1'b0;
         enc_val_in     = {7'd0, enc_val_ff[63:GROUP_W]};
         enc_cnt_in     = enc_cnt_ff + 4'd1;
         enc_active_in  = enc_more;
      end else if (req_fire) begin
         case (req_operation)
            OP_ENCODE: begin
               // The first byte leaves at once; the rest go through the shifter.
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_BYTE;
               rsp_byte_in    = {enc_mapped[63:GROUP_W] != '0, enc_mapped[GROUP_W-1:0]};
               rsp_value_in   = '0;
               rsp_last_in    = enc_mapped[63:GROUP_W] == '0;
               rsp_overrun_in = 1'b0;
               enc_val_in     = {7'd0, enc_mapped[63:GROUP_W]};
               enc_cnt_in     = 4'd1;
               enc_active_in  = enc_mapped[63:GROUP_W] != '0;
            end
            OP_DECODE: begin
               if (req_byte_in[CONT_POS] && byte_cnt_ff == LAST_GROUP) begin
                  // Ten bytes without a terminator: abandon and restart.
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_VALUE;
                  rsp_byte_in    = '0;
                  rsp_value_in   = '0;
                  rsp_last_in    = 1'b1;
                  rsp_overrun_in = 1'b1;
                  acc_in         = '0;
                  byte_cnt_in    = '0;
               end else if (req_byte_in[CONT_POS]) begin
                  acc_in      = acc_ins;
                  byte_cnt_in = byte_cnt_ff + 4'd1;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_VALUE;
                  rsp_byte_in    = '0;
                  rsp_value_in   = dec_value;
                  rsp_last_in    = 1'b1;
                  rsp_overrun_in = 1'b0;
                  acc_in         = '0;
                  byte_cnt_in    = '0;
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_ready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         enc_active_ff <= 1'b0;
         enc_cnt_ff    <= '0;
         acc_ff        <= '0;
         byte_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         enc_active_ff <= enc_active_in;
         enc_cnt_ff    <= enc_cnt_in;
         acc_ff        <= acc_in;
         byte_cnt_ff   <= byte_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff    <= rsp_kind_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_overrun_ff <= rsp_overrun_in;
      enc_val_ff     <= enc_val_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_byte_out  = rsp_byte_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_overrun   = rsp_overrun_ff;

   // The decoder never counts past the tenth group.
   `VZC_ASSERT_NOW(a_cnt_range, 1'b1, byte_cnt_ff <= LAST_GROUP)
   // An encoder run in progress always has a byte waiting in the result register.
   `VZC_ASSERT_NOW(a_enc_holds_out, enc_active_ff, rsp_valid_ff)
   // A non-final encoded byte means the shifter still has groups to send.
   `VZC_ASSERT_NOW(a_enc_more, rsp_valid_ff && rsp_kind_ff == KIND_BYTE && !rsp_last_ff,
                   enc_active_ff)
   // An overrun result is a final, empty value.
   `VZC_ASSERT_NOW(a_overrun_empty, rsp_valid_ff && rsp_overrun_ff,
                   rsp_value_ff == '0 && rsp_last_ff && rsp_kind_ff == KIND_VALUE)
   // An abandoned varint restarts the decoder from the first group.
   `VZC_ASSERT_NEXT(a_overrun_clear,
                    req_fire && req_operation == OP_DECODE && req_byte_in[CONT_POS]
                    && byte_cnt_ff == LAST_GROUP && !enc_active_ff,
                    byte_cnt_ff == '0 && acc_ff == '0)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the varint / zigzag codec. Items go in through the req_
// channel and results come back through the rsp_ channel; both sides idle at random.
// A predictor written below tracks the decoder accumulator and group count,
// and queues the bytes or values that each accepted item must produce.
module tb_top;
   import vzc_pkg::*;

   // Mode bits of an item, named so that the stimulus table reads plainly.
   localparam logic N32    = 1'b0;
   localparam logic N64    = 1'b1;
   localparam logic PLAIN  = 1'b0;
   localparam logic ZIGZAG = 1'b1;

   localparam int TOTAL_ITEMS  = 370;
   localparam int STALL_LIMIT  = 400;
   localparam int DRAIN_CYCLES = 24;
   localparam int RESET_CYCLES = 6;

   // One result item as it appears on the rsp_ ports.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_out;
      logic [63:0] value_out;
      logic        last;
      logic        overrun;
   } codec_result_type;

   // One row of the directed table. A row is sent reps times in a row; where
   // typed is set, the result of its final repetition is the one given here.
   typedef struct packed {
      op_type           op;
      logic [63:0]      value;
      logic [7:0]       byte_in;
      logic             wide;
      logic             sgn;
      int               reps;
      logic             typed;
      codec_result_type want;
   } stim_row_type;

   typedef logic [7:0] group_bytes_type [MAX_GROUPS];

   localparam codec_result_type NO_RESULT = '{KIND_BYTE, 8'h00, 64'h0, 1'b0, 1'b0};
   localparam int DIRECTED_ROWS = 24;

   // The first rows hit encode extremes; the rest walk the decoder through
   // full ten-byte varints, overrun, narrow truncation and interleaved encodes.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_ENCODE, 64'h0, 8'h00, N32, PLAIN, 1, 1'b1,
        '{KIND_BYTE, 8'h00, 64'h0, 1'b1, 1'b0}},
      '{OP_ENCODE, 64'h7F, 8'h00, N32, PLAIN, 1, 1'b1,
        '{KIND_BYTE, 8'h7F, 64'h0, 1'b1, 1'b0}},
      '{OP_ENCODE, 64'h80, 8'h00, N32, PLAIN, 1, 1'b0, NO_RESULT},
      '{OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, N64, PLAIN, 1, 1'b0, NO_RESULT},
      '{OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, N32, PLAIN, 1, 1'b0, NO_RESULT},
      '{OP_ENCODE, 64'hDEAD_BEEF_0000_0080, 8'h00, N32, PLAIN, 1, 1'b0, NO_RESULT},
      '{OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, N32, ZIGZAG, 1, 1'b0, NO_RESULT},
      '{OP_ENCODE, 64'h8000_0000_0000_0000, 8'h00, N64, ZIGZAG, 1, 1'b0, NO_RESULT},
      '{OP_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00, N64, ZIGZAG, 1, 1'b0, NO_RESULT},
      '{OP_ENCODE, 64'h0000_0000_8000_0000, 8'h00, N32, ZIGZAG, 1, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'h00, N32, PLAIN, 1, 1'b1,
        '{KIND_VALUE, 8'h00, 64'h0, 1'b1, 1'b0}},
      '{OP_DECODE, 64'h0, 8'hFF, N64, PLAIN, 9, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'h7F, N64, PLAIN, 1, 1'b1,
        '{KIND_VALUE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0}},
      '{OP_DECODE, 64'h0, 8'hFF, N64, PLAIN, 10, 1'b1,
        '{KIND_VALUE, 8'h00, 64'h0, 1'b1, 1'b1}},
      '{OP_DECODE, 64'h0, 8'h01, N32, ZIGZAG, 1, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'h85, N64, PLAIN, 1, 1'b0, NO_RESULT},
      '{OP_ENCODE, 64'h12345, 8'h00, N64, PLAIN, 1, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'h01, N32, ZIGZAG, 1, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'hFF, N32, PLAIN, 4, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'h0F, N32, ZIGZAG, 1, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'hFF, N32, ZIGZAG, 9, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'h01, N64, ZIGZAG, 1, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'hFF, N64, PLAIN, 4, 1'b0, NO_RESULT},
      '{OP_DECODE, 64'h0, 8'h7F, N32, PLAIN, 1, 1'b0, NO_RESULT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   op_type      req_operation = OP_ENCODE;
   logic [63:0] req_value = 64'h0;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_is_wide = 1'b0;
   logic        req_is_signed = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   kind_type    rsp_kind;
   logic [7:0]  rsp_byte_out;
   logic [63:0] rsp_value_out;
   logic        rsp_last;
   logic        rsp_overrun;

   // Predictor state: the decoder's gathered payload and how many
   // continuation bytes it has seen.
   logic [63:0] gathered;
   count_type   groups_seen;

   codec_result_type expected_results [$];
   int          mismatches = 0;
   int          items_sent = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   varint_zigzag_codec u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_byte_in   (req_byte_in),
      .req_is_wide   (req_is_wide),
      .req_is_signed (req_is_signed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_value_out (rsp_value_out),
      .rsp_last      (rsp_last),
      .rsp_overrun   (rsp_overrun)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Appends one expected result at the tail of the queue.
   function automatic void queue_result(input codec_result_type r);
      expected_results = {expected_results, r};
   endfunction

   // Zigzag folds the sign into bit 0. In narrow mode only the low word takes
   // part and the upper word of the result stays clear.
   function automatic logic [63:0] zigzag_fold(input logic [63:0] v, input logic wide);
      if (wide)
         return (v << 1) ^ {64{v[63]}};
      return {32'h0, (v[31:0] << 1) ^ {32{v[31]}}};
   endfunction

   // The inverse mapping; a narrow result is sign-extended to 64 bits.
   function automatic logic [63:0] zigzag_unfold(input logic [63:0] v, input logic wide);
      logic [31:0] low;
      if (wide)
         return (v >> 1) ^ {64{v[0]}};
      low = (v[31:0] >> 1) ^ {32{v[0]}};
      return {{32{low[31]}}, low};
   endfunction

   // Splits a value into its varint bytes, least significant group first.
   // Returns the number of bytes; the last one has bit 7 clear.
   function automatic int varint_bytes(input logic [63:0] value, input logic wide,
                                       input logic sgn, output group_bytes_type grp);
      logic [63:0] v;
      int n;
      v = sgn ? zigzag_fold(value, wide) : value;
      if (!wide)
         v = {32'h0, v[31:0]};
      n = 0;
      while (v >= 64'h80 && n < MAX_GROUPS - 1) begin
         grp[n] = {1'b1, v[6:0]};
         v = v >> GROUP_W;
         n++;
      end
      grp[n] = v[7:0];
      return n + 1;
   endfunction

   // Works out what one accepted item produces and queues it.
   function automatic void predict_codec(input op_type op, input logic [63:0] value,
                                         input logic [7:0] b, input logic wide,
                                         input logic sgn);
      group_bytes_type grp;
      int n;
      logic [63:0] v;
      if (op == OP_ENCODE) begin
         n = varint_bytes(value, wide, sgn, grp);
         for (int i = 0; i < n; i++)
            queue_result('{KIND_BYTE, grp[i], 64'h0, i == n - 1, 1'b0});
         return;
      end
      // Payload bits shifted past bit 63 fall off the top of the register.
      gathered = gathered | ({57'h0, b[6:0]} << (GROUP_W * int'(groups_seen)));
      if (b[CONT_POS]) begin
         if (groups_seen >= LAST_GROUP) begin
            gathered = 64'h0;
            groups_seen = '0;
            queue_result('{KIND_VALUE, 8'h00, 64'h0, 1'b1, 1'b1});
         end else begin
            groups_seen = groups_seen + 4'd1;
         end
         return;
      end
      // The terminating byte's own mode bits decide how the value is read.
      v = wide ? gathered : {32'h0, gathered[31:0]};
      if (sgn)
         v = zigzag_unfold(v, wide);
      gathered = 64'h0;
      groups_seen = '0;
      queue_result('{KIND_VALUE, 8'h00, v, 1'b1, 1'b0});
   endfunction

   function automatic logic [63:0] draw_value();
      logic [63:0] v;
      v = {$urandom, $urandom} >> $urandom_range(0, 63);
      if ($urandom_range(0, 3) == 0)
         v = ~v;
      return v;
   endfunction

   // Presents one item and returns in the time step of its acceptance. Valid is
   // only lowered when a gap follows, so back-to-back items keep it high.
   task automatic send_item(input op_type op, input logic [63:0] value,
                            input logic [7:0] b, input logic wide, input logic sgn);
      int gap;
      if ($urandom_range(0, 39) == 0)
         req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= value;
      req_byte_in   <= b;
      req_is_wide   <= wide;
      req_is_signed <= sgn;
      do
         @(posedge clock);
      while (!req_ready);
      predict_codec(op, value, b, wide, sgn);
      items_sent++;
   endtask

   // Result side: an idle gap before each result, then the comparison against
   // the oldest expectation, field by field.
   initial begin
      codec_result_type want;
      int gap;
      while (reset)
         @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_calm = !rsp_calm;
         gap = rsp_calm ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_valid);
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d byte %h value %h",
                                      rsp_kind, rsp_byte_out, rsp_value_out));
         end else begin
            want = expected_results.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
            if (rsp_byte_out !== want.byte_out)
               report_mismatch($sformatf("byte_out %h, expected %h",
                                         rsp_byte_out, want.byte_out));
            if (rsp_value_out !== want.value_out)
               report_mismatch($sformatf("value_out %h, expected %h",
                                         rsp_value_out, want.value_out));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0d, expected %0d", rsp_last, want.last));
            if (rsp_overrun !== want.overrun)
               report_mismatch($sformatf("overrun %0d, expected %0d",
                                         rsp_overrun, want.overrun));
         end
      end
   end

   // Watchdog: a run of cycles in which neither channel moves an item means
   // the block has hung or dropped a result.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no item moved for %0d cycles, %0d results pending",
                     $time, idle_cycles, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      group_bytes_type grp;
      int n;
      int pick;
      logic [63:0] v;
      logic wide;
      logic sgn;
      gathered = 64'h0;
      groups_seen = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. Typed rows swap the predicted result for the one
      // written in the table, which is plain from the encoding rules.
      foreach (DIRECTED[i]) begin
         for (int k = 0; k < DIRECTED[i].reps; k++)
            send_item(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].byte_in,
                      DIRECTED[i].wide, DIRECTED[i].sgn);
         if (DIRECTED[i].typed) begin
            void'(expected_results.pop_back());
            queue_result(DIRECTED[i].want);
         end
      end

      // Random part. Half of it feeds the decoder well-formed varints built
      // from random values; the rest is encodes, stray bytes and long runs of
      // continuation bytes that can force an overrun. It runs until the whole
      // bench, directed rows included, has sent its share of items.
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         wide = 1'($urandom_range(0, 1));
         sgn  = 1'($urandom_range(0, 1));
         if (pick < 35) begin
            send_item(OP_ENCODE, draw_value(), 8'($urandom), wide, sgn);
         end else if (pick < 85) begin
            n = varint_bytes(draw_value(), wide, sgn, grp);
            for (int i = 0; i < n; i++) begin
               // Now and then an encode slips in between decode bytes.
               if ($urandom_range(0, 9) == 0)
                  send_item(OP_ENCODE, draw_value(), 8'($urandom), 1'($urandom),
                            1'($urandom));
               if (i < n - 1)
                  send_item(OP_DECODE, draw_value(), grp[i], 1'($urandom),
                            1'($urandom));
               else if ($urandom_range(0, 9) == 0)
                  send_item(OP_DECODE, draw_value(), grp[i], !wide, 1'($urandom));
               else
                  send_item(OP_DECODE, draw_value(), grp[i], wide, sgn);
            end
         end else if (pick < 93) begin
            send_item(OP_DECODE, draw_value(), 8'($urandom), wide, sgn);
         end else begin
            repeat ($urandom_range(5, 12))
               send_item(OP_DECODE, draw_value(), 8'($urandom_range(8'h80, 8'hFF)),
                         wide, sgn);
         end
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
